// ----- rtl/core/pgxlat_pkg.sv -----
// pgxlat_pkg: types, codes and sizes shared by the page table address translator
// no dependencies; imported by the channel interfaces and the top level
`default_nettype none

package pgxlat_pkg;

    // table and page geometry (table size is a power of two)
    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int PAGE_BYTES    = 2048;
    localparam int OFFS_W        = $clog2(PAGE_BYTES);
    // page number inside a 32-page group
    localparam int PAGE_W        = 16 - OFFS_W;
    // wide enough for base + page and for the entry index
    localparam int SUM_W         = (IDX_W > 7) ? IDX_W : 7;

    // configuration register indexes
    localparam logic [1:0] CFG_STORAGE_BYTES = 2'd0;
    localparam logic [1:0] CFG_GUEST_BASE    = 2'd1;
    localparam logic [1:0] CFG_PROTECT_MASK  = 2'd2;
    localparam logic [1:0] CFG_PACT_MASK     = 2'd3;

    localparam int CFG_W = 25;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_RESOLVE = 2'd1,
        OP_RANGE   = 2'd2,
        OP_GUEST   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_PROTECT = 2'd1,
        ST_BOUND   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_EMIT
    } state_t;

    typedef struct packed {
        op_t         opcode;
        logic [15:0] logical_addr;
        logic [23:0] guest_field;
        logic [7:0]  pact_byte;
        logic [5:0]  table_base;
        logic [15:0] range_length;
        logic        for_write;
        logic [5:0]  entry_index;
        logic [15:0] entry_value;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [23:0] real_addr;
        logic [15:0] extent_len;
        logic [15:0] fault_addr;
        logic        fault_was_write;
        logic        last;
    } rsp_t;

endpackage

`default_nettype wire

// ----- rtl/core/pgxlat_req_if.sv -----
// pgxlat_req_if: request channel into the translator (valid, ready, payload)
// depends on pgxlat_pkg for the request type
`default_nettype none

interface pgxlat_req_if
    import pgxlat_pkg::*;
();
    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/pgxlat_rsp_if.sv -----
// pgxlat_rsp_if: result channel out of the translator (valid, ready, payload)
// depends on pgxlat_pkg for the result type
`default_nettype none

interface pgxlat_rsp_if
    import pgxlat_pkg::*;
();
    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/page_table_address_translator.sv -----
// page_table_address_translator: translation table, range walker and result register
// depends on pgxlat_pkg, pgxlat_req_if and pgxlat_rsp_if
//
// channel   direction  handshake           carries
// req       in         valid/ready         opcode and operand fields
// rsp       out        valid/ready         status, extent and fault report
// cfg       in         cfg_we, no wait     register index and data
//
// a table write returns to idle; a direct resolve, direct guest or empty range goes
// straight to emit; a translated resolve or range walks each page (table read, then
// evaluate) and sends the final result from emit.
// a new request is taken only in idle; one finished result may wait in the
// output register while the next request starts. a stalled output holds the
// walk. reset is asynchronous; the table holds no reset value.
`default_nettype none

module page_table_address_translator
    import pgxlat_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    pgxlat_req_if.sink            req,
    pgxlat_rsp_if.source          rsp
);

    // configuration registers
    logic [24:0] storage_bytes_reg;
    logic [5:0]  guest_base_reg;
    logic [7:0]  protect_mask_reg;
    logic [7:0]  pact_mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            storage_bytes_reg <= 25'd1048576;
            guest_base_reg    <= 6'd0;
            protect_mask_reg  <= 8'd128;
            pact_mask_reg     <= 8'd127;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_STORAGE_BYTES: storage_bytes_reg <= cfg_data[24:0];
                CFG_GUEST_BASE:    guest_base_reg    <= cfg_data[5:0];
                CFG_PROTECT_MASK:  protect_mask_reg  <= cfg_data[7:0];
                CFG_PACT_MASK:     pact_mask_reg     <= cfg_data[7:0];
                default:           pact_mask_reg     <= pact_mask_reg;
            endcase
        end
    end

    // sequencer and walk registers
    state_t      state_reg, state_next;
    logic [15:0] walk_addr_reg, walk_addr_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [23:0] pend_start_reg, pend_start_next;
    logic [15:0] pend_len_reg, pend_len_next;
    logic [5:0]  base_reg, base_next;
    logic        fw_reg, fw_next;
    logic        single_reg, single_next;
    rsp_t        res_reg, res_next;
    logic        out_valid_reg, out_valid_next;
    rsp_t        out_reg, out_next;

    // translation table
    logic [15:0]      table_mem [TABLE_ENTRIES];
    logic [15:0]      rd_data_reg;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic [SUM_W-1:0] rd_sum;
    logic [SUM_W-1:0] wr_sum;

    req_t req_d;
    logic req_fire;
    logic out_free;

    // evaluation of one page
    logic        pg_bad;
    logic [23:0] pg_real;
    logic [11:0] in_page;
    logic [15:0] chunk;
    logic [15:0] left_after;
    logic [24:0] pend_end;
    logic        merge;
    logic        flush;
    logic [23:0] new_start;
    logic [15:0] new_len;

    // direct paths
    logic [24:0] guest_end;
    logic        direct_resolve;

    assign req_d    = req.data;
    assign req_fire = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || rsp.ready;

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    // table addressing, index wraps modulo the table size
    assign wr_en  = req_fire && (req_d.opcode == OP_WRITE);
    assign wr_sum = SUM_W'(req_d.entry_index);
    assign wr_idx = wr_sum[IDX_W-1:0];
    assign rd_en  = (state_reg == S_READ);
    assign rd_sum = SUM_W'(base_reg) + SUM_W'(walk_addr_reg[15:OFFS_W]);
    assign rd_idx = rd_sum[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_idx] <= req_d.entry_value;
        end
        if (rd_en)
        begin
            rd_data_reg <= table_mem[rd_idx];
        end
    end

    // page evaluation from the registered table word
    assign pg_bad     = |rd_data_reg[15:13];
    assign pg_real    = {rd_data_reg[12:0], walk_addr_reg[OFFS_W-1:0]};
    assign in_page    = 12'(PAGE_BYTES) - {1'b0, walk_addr_reg[OFFS_W-1:0]};
    assign chunk      = ({4'd0, in_page} < bytes_left_reg) ? {4'd0, in_page} : bytes_left_reg;
    assign left_after = bytes_left_reg - chunk;
    assign pend_end   = {1'b0, pend_start_reg} + {9'd0, pend_len_reg};
    assign merge      = (pend_len_reg != 16'd0) && (pend_end == {1'b0, pg_real});
    assign flush      = (pend_len_reg != 16'd0) && !merge;
    assign new_start  = merge ? pend_start_reg : pg_real;
    assign new_len    = merge ? (pend_len_reg + chunk) : chunk;

    // direct checks at request time
    assign guest_end      = {2'd0, req_d.guest_field[22:0]} + {9'd0, req_d.range_length};
    assign direct_resolve = ((req_d.pact_byte & protect_mask_reg) == 8'd0);

    // next state, walk updates and result pushes
    always_comb
    begin
        state_next      = state_reg;
        walk_addr_next  = walk_addr_reg;
        bytes_left_next = bytes_left_reg;
        pend_start_next = pend_start_reg;
        pend_len_next   = pend_len_reg;
        base_next       = base_reg;
        fw_next         = fw_reg;
        single_next     = single_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_next        = out_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    res_next   = '0;
                    res_next.status = ST_OK;
                    res_next.last   = 1'b1;
                    fw_next         = req_d.for_write;
                    pend_start_next = 24'd0;
                    pend_len_next   = 16'd0;
                    bytes_left_next = req_d.range_length;
                    single_next     = 1'b0;
                    unique case (req_d.opcode)
                        OP_WRITE:
                        begin
                            state_next = S_IDLE;
                        end
                        OP_RESOLVE:
                        begin
                            walk_addr_next = req_d.logical_addr;
                            base_next      = req_d.table_base;
                            single_next    = 1'b1;
                            if (direct_resolve)
                            begin
                                res_next.real_addr = {req_d.pact_byte & pact_mask_reg,
                                                      req_d.logical_addr};
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                        OP_RANGE:
                        begin
                            walk_addr_next = req_d.logical_addr;
                            base_next      = req_d.table_base;
                            state_next = (req_d.range_length == 16'd0) ? S_EMIT : S_READ;
                        end
                        OP_GUEST:
                        begin
                            if (req_d.guest_field[23])
                            begin
                                walk_addr_next = req_d.guest_field[15:0];
                                base_next      = guest_base_reg;
                                state_next = (req_d.range_length == 16'd0) ? S_EMIT : S_READ;
                            end
                            else
                            begin
                                // direct range with storage bound check
                                if (guest_end > storage_bytes_reg)
                                begin
                                    res_next.status          = ST_BOUND;
                                    res_next.real_addr       = {1'b0, req_d.guest_field[22:0]};
                                    res_next.fault_was_write = req_d.for_write;
                                end
                                else if (req_d.range_length != 16'd0)
                                begin
                                    res_next.real_addr  = {1'b0, req_d.guest_field[22:0]};
                                    res_next.extent_len = req_d.range_length;
                                end
                                state_next = S_EMIT;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_READ:
            begin
                state_next = S_EVAL;
            end

            S_EVAL:
            begin
                res_next = '0;
                res_next.status = ST_OK;
                res_next.last   = 1'b1;
                if (pg_bad)
                begin
                    // protection fault ends the item
                    res_next.status          = ST_PROTECT;
                    res_next.fault_addr      = walk_addr_reg;
                    res_next.fault_was_write = fw_reg;
                    pend_len_next            = 16'd0;
                    state_next               = S_EMIT;
                end
                else if (single_reg)
                begin
                    res_next.real_addr = pg_real;
                    state_next         = S_EMIT;
                end
                else if (flush && !out_free)
                begin
                    // hold until the previous extent can be sent
                    res_next   = res_reg;
                    state_next = S_EVAL;
                end
                else
                begin
                    if (flush)
                    begin
                        out_valid_next      = 1'b1;
                        out_next            = '0;
                        out_next.status     = ST_OK;
                        out_next.real_addr  = pend_start_reg;
                        out_next.extent_len = pend_len_reg;
                    end
                    pend_start_next = new_start;
                    pend_len_next   = new_len;
                    bytes_left_next = left_after;
                    walk_addr_next  = walk_addr_reg + chunk;
                    if (left_after == 16'd0)
                    begin
                        res_next.real_addr  = new_start;
                        res_next.extent_len = new_len;
                        state_next          = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and walk registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            walk_addr_reg  <= 16'd0;
            bytes_left_reg <= 16'd0;
            pend_start_reg <= 24'd0;
            pend_len_reg   <= 16'd0;
            single_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            walk_addr_reg  <= walk_addr_next;
            bytes_left_reg <= bytes_left_next;
            pend_start_reg <= pend_start_next;
            pend_len_reg   <= pend_len_next;
            single_reg     <= single_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        fw_reg   <= fw_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

endmodule

`default_nettype wire

// ----- tb/page_table_address_translator_tb.sv -----
// page_table_address_translator_tb: self-checking bench for the page table address translator
// it predicts every request's results and checks them against the result channel, field by field
// depends on pgxlat_pkg, pgxlat_req_if, pgxlat_rsp_if and the page_table_address_translator rtl
module page_table_address_translator_tb;
    import pgxlat_pkg::*;

    localparam int CYCLE_LIMIT    = 600000;
    localparam int ITEMS_PER_STEP = 24;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 20;
    localparam int HOLD_CYCLES    = 400;
    localparam int REPORT_LIMIT   = 10;

    // translation table, registers and the results each request should produce
    class translation_tracker;
        logic [15:0]      page_words [TABLE_ENTRIES];
        logic [CFG_W-1:0] storage_size;
        logic [5:0]       guest_base;
        logic [7:0]       protect_mask;
        logic [7:0]       addr_mask;
        rsp_t             xlat_results [$];
        int               failures;

        function new();
            foreach (page_words[i])
                page_words[i] = '0;
            storage_size = 25'd1048576;
            guest_base   = 6'd0;
            protect_mask = 8'h80;
            addr_mask    = 8'h7F;
            failures     = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                CFG_STORAGE_BYTES: storage_size = value;
                CFG_GUEST_BASE:    guest_base   = value[5:0];
                CFG_PROTECT_MASK:  protect_mask = value[7:0];
                CFG_PACT_MASK:     addr_mask    = value[7:0];
                default:           ;
            endcase
        endfunction

        function void add_result(status_t st, logic [23:0] addr, logic [15:0] len,
                                 logic [15:0] fault, logic wr, logic fin);
            rsp_t x;
            x.status          = st;
            x.real_addr       = addr;
            x.extent_len      = len;
            x.fault_addr      = fault;
            x.fault_was_write = wr;
            x.last            = fin;
            xlat_results.insert(xlat_results.size(), x);
        endfunction

        // one table read for the page that holds this logical address
        function bit page_lookup(input logic [15:0] logical, input logic [5:0] base,
                                 output logic [23:0] phys);
            int unsigned idx;
            logic [15:0] word;
            idx  = (int'(base) + int'(logical[15:OFFS_W])) % TABLE_ENTRIES;
            word = page_words[idx];
            phys = '0;
            if (word[15:13] != 3'b000)
                return 1'b0;
            phys = {word[12:0], logical[OFFS_W-1:0]};
            return 1'b1;
        endfunction

        // page by page walk, merging extents that continue in real storage
        function void walk_range(logic [15:0] start, logic [5:0] base, logic [15:0] len,
                                 logic wr);
            logic [15:0] addr;
            logic [23:0] phys;
            logic [23:0] run_start;
            int unsigned run_len;
            int unsigned left;
            int unsigned in_page;
            int unsigned chunk;
            addr      = start;
            left      = len;
            run_start = '0;
            run_len   = 0;
            if (left == 0)
            begin
                add_result(ST_OK, '0, '0, '0, 1'b0, 1'b1);
                return;
            end
            while (left > 0)
            begin
                if (!page_lookup(addr, base, phys))
                begin
                    add_result(ST_PROTECT, '0, '0, addr, wr, 1'b1);
                    return;
                end
                in_page = PAGE_BYTES - int'(addr[OFFS_W-1:0]);
                chunk   = (in_page < left) ? in_page : left;
                if (run_len != 0 && 32'(run_start) + run_len == 32'(phys))
                    run_len += chunk;
                else
                begin
                    if (run_len != 0)
                        add_result(ST_OK, run_start, 16'(run_len), '0, 1'b0, 1'b0);
                    run_start = phys;
                    run_len   = chunk;
                end
                left -= chunk;
                addr  = addr + 16'(chunk);
            end
            add_result(ST_OK, run_start, 16'(run_len), '0, 1'b0, 1'b1);
        endfunction

        // works out the results of one accepted request
        function void note_request(req_t r);
            logic [23:0] phys;
            logic [22:0] direct;
            case (r.opcode)
                OP_WRITE:
                    page_words[int'(r.entry_index) % TABLE_ENTRIES] = r.entry_value;
                OP_RESOLVE:
                    if ((r.pact_byte & protect_mask) == 8'h00)
                        add_result(ST_OK, {r.pact_byte & addr_mask, r.logical_addr}, '0, '0,
                                   1'b0, 1'b1);
                    else if (page_lookup(r.logical_addr, r.table_base, phys))
                        add_result(ST_OK, phys, '0, '0, 1'b0, 1'b1);
                    else
                        add_result(ST_PROTECT, '0, '0, r.logical_addr, r.for_write, 1'b1);
                OP_RANGE:
                    walk_range(r.logical_addr, r.table_base, r.range_length, r.for_write);
                default:
                    if (r.guest_field[23])
                        walk_range(r.guest_field[15:0], guest_base, r.range_length,
                                   r.for_write);
                    else
                    begin
                        direct = r.guest_field[22:0];
                        if (32'(direct) + 32'(r.range_length) > 32'(storage_size))
                            add_result(ST_BOUND, {1'b0, direct}, '0, '0, r.for_write, 1'b1);
                        else if (r.range_length == 16'd0)
                            add_result(ST_OK, '0, '0, '0, 1'b0, 1'b1);
                        else
                            add_result(ST_OK, {1'b0, direct}, r.range_length, '0, 1'b0,
                                       1'b1);
                    end
            endcase
        endfunction

        function string describe(rsp_t x);
            return $sformatf("status=%0d addr=%h len=%h fault=%h wr=%b last=%b",
                             x.status, x.real_addr, x.extent_len, x.fault_addr,
                             x.fault_was_write, x.last);
        endfunction

        function void check_result(rsp_t got);
            rsp_t want;
            if (xlat_results.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("result with nothing outstanding: %s", describe(got));
                return;
            end
            want = xlat_results.pop_front();
            if (got.status !== want.status || got.real_addr !== want.real_addr ||
                got.extent_len !== want.extent_len || got.fault_addr !== want.fault_addr ||
                got.fault_was_write !== want.fault_was_write || got.last !== want.last)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("result mismatch: expected %s, got %s",
                             describe(want), describe(got));
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [1:0]       cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic             stall_hold;
    logic             hold_armed;
    int               send_idle_pct;
    int               recv_idle_pct;
    int               cycle_count;

    translation_tracker tracker = new();

    pgxlat_req_if req_ch();
    pgxlat_rsp_if rsp_ch();

    page_table_address_translator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("page_table_address_translator test failed");
                $finish;
            end
        end
    end

    // result side backpressure, with random gaps and one long hold-off
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= !stall_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // long receiver hold-off while requests keep coming, so the block backs up
    initial
    begin
        stall_hold <= 1'b0;
        wait (hold_armed);
        repeat (30) @(posedge clk);
        stall_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        stall_hold <= 1'b0;
    end

    // result check
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            tracker.check_result(rsp_ch.data);
    end

    // request with every field random inside its range, then the given key fields
    function automatic req_t shaped(op_t op, logic [15:0] la, logic [5:0] base,
                                    logic [15:0] len);
        req_t r;
        r.opcode       = op;
        r.logical_addr = la;
        r.guest_field  = 24'($urandom);
        r.pact_byte    = 8'($urandom);
        r.table_base   = base;
        r.range_length = len;
        r.for_write    = 1'($urandom);
        r.entry_index  = 6'($urandom);
        r.entry_value  = 16'($urandom);
        return r;
    endfunction

    // random request mix: table updates, single resolves, range walks and guest requests
    function automatic req_t random_request();
        req_t r;
        int pick;
        logic [15:0] len;
        logic [15:0] neighbor;
        logic [12:0] frame;
        pick = $urandom_range(99);
        case ($urandom_range(9))
            0:       len = 16'd0;
            1:       len = 16'($urandom_range(65535, 6145));
            default: len = 16'($urandom_range(6144, 1));
        endcase
        if (pick < 20)
        begin
            r = shaped(OP_WRITE, 16'($urandom), 6'($urandom_range(32)), len);
            // often continue the frame of the entry below, so walks can merge
            neighbor = tracker.page_words[(int'(r.entry_index) + TABLE_ENTRIES - 1)
                                          % TABLE_ENTRIES];
            frame = $urandom_range(1) ? neighbor[12:0] + 13'd1 : 13'($urandom);
            if ($urandom_range(9) == 0)
                r.entry_value = {3'($urandom_range(7, 1)), frame};
            else
                r.entry_value = {3'b000, frame};
        end
        else if (pick < 40)
            r = shaped(OP_RESOLVE, 16'($urandom), 6'($urandom_range(32)), len);
        else
        begin
            r = shaped((pick < 75) ? OP_RANGE : OP_GUEST, 16'($urandom),
                       6'($urandom_range(32)), len);
            if ($urandom_range(1))
            begin
                r.logical_addr[OFFS_W-1:0] = '0;
                r.guest_field[OFFS_W-1:0]  = '0;
            end
        end
        return r;
    endfunction

    // offer one request, with random idle cycles first, until it is taken
    task automatic send_request(input req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        tracker.note_request(r);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        tracker.set_register(idx, value);
        @(posedge clk);
    endtask

    task automatic program_registers(input logic [CFG_W-1:0] size, input logic [5:0] gbase,
                                     input logic [7:0] pmask, input logic [7:0] amask);
        write_register(CFG_STORAGE_BYTES, size);
        write_register(CFG_GUEST_BASE, CFG_W'(gbase));
        write_register(CFG_PROTECT_MASK, CFG_W'(pmask));
        write_register(CFG_PACT_MASK, CFG_W'(amask));
        cfg_we <= 1'b0;
    endtask

    // stop offering and wait until the block has gone idle
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (tracker.xlat_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // field extremes and each corner of resolve, walk and guest handling
    task automatic run_directed();
        req_t r;
        // direct resolves
        r = shaped(OP_RESOLVE, 16'hFFFF, 6'd0, 16'd0);
        r.pact_byte = 8'h00;
        send_request(r);
        r = shaped(OP_RESOLVE, 16'h0000, 6'd0, 16'd0);
        r.pact_byte = 8'h7F;
        send_request(r);
        // translated resolves: top of table, bottom, and an invalid page
        r = shaped(OP_RESOLVE, 16'hFFFF, 6'd32, 16'd0);
        r.pact_byte = 8'hFF;
        send_request(r);
        r = shaped(OP_RESOLVE, 16'h0000, 6'd0, 16'd0);
        r.pact_byte = 8'h80;
        send_request(r);
        r = shaped(OP_RESOLVE, 16'h3800, 6'd0, 16'd0);
        r.pact_byte = 8'h80;
        r.for_write = 1'b1;
        send_request(r);
        // walks: empty, one byte, one page, merge across pages
        send_request(shaped(OP_RANGE, 16'h1234, 6'd0, 16'd0));
        send_request(shaped(OP_RANGE, 16'h0000, 6'd0, 16'd1));
        send_request(shaped(OP_RANGE, 16'h0800, 6'd0, 16'd2048));
        send_request(shaped(OP_RANGE, 16'h07FF, 6'd0, 16'd2));
        // longest walk, no page merges, wraps back to page zero
        send_request(shaped(OP_RANGE, 16'h0400, 6'd32, 16'hFFFF));
        // wrap at 64K
        send_request(shaped(OP_RANGE, 16'hFF00, 6'd0, 16'h0200));
        // fault after merged pages, and fault on the first page
        r = shaped(OP_RANGE, 16'h2000, 6'd0, 16'h4000);
        r.for_write = 1'b1;
        send_request(r);
        r = shaped(OP_RANGE, 16'h3900, 6'd0, 16'h0010);
        r.for_write = 1'b0;
        send_request(r);
        // guest fields: translated, direct empty, exact fit, past storage, longest
        r = shaped(OP_GUEST, 16'h0000, 6'd0, 16'h0100);
        r.guest_field = 24'hFFFFFF;
        send_request(r);
        r = shaped(OP_GUEST, 16'h0000, 6'd0, 16'd0);
        r.guest_field = 24'h7FFFFF;
        send_request(r);
        r = shaped(OP_GUEST, 16'h0000, 6'd0, 16'd1);
        r.guest_field = 24'h7FFFFF;
        send_request(r);
        r = shaped(OP_GUEST, 16'h0000, 6'd0, 16'd2);
        r.guest_field = 24'h7FFFFF;
        r.for_write   = 1'b1;
        send_request(r);
        r = shaped(OP_GUEST, 16'h0000, 6'd0, 16'hFFFF);
        r.guest_field = 24'h000000;
        send_request(r);
        // repair the invalid page, then walk across it
        r = shaped(OP_WRITE, 16'h0000, 6'd0, 16'd0);
        r.entry_index = 6'd7;
        r.entry_value = 16'h0007;
        send_request(r);
        send_request(shaped(OP_RANGE, 16'h3000, 6'd0, 16'h1000));
        // all invalid bits on the top entry, resolve it, then restore
        r = shaped(OP_WRITE, 16'h0000, 6'd0, 16'd0);
        r.entry_index = 6'd63;
        r.entry_value = 16'hFFFF;
        send_request(r);
        r = shaped(OP_RESOLVE, 16'hF800, 6'd32, 16'd0);
        r.pact_byte = 8'h80;
        r.for_write = 1'b0;
        send_request(r);
        r = shaped(OP_WRITE, 16'h0000, 6'd0, 16'd0);
        r.entry_index = 6'd63;
        r.entry_value = 16'h1FFF;
        send_request(r);
    endtask

    // main sequence
    initial
    begin
        req_t r;
        req_ch.valid  <= 1'b0;
        req_ch.data   <= '0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_STORAGE_BYTES;
        cfg_data      <= '0;
        hold_armed    <= 1'b0;
        send_idle_pct <= 22;
        recv_idle_pct <= 51;
        rst_n         <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        program_registers(25'h0800000, 6'd0, 8'h80, 8'h7F);

        // fill the whole table before any lookup: low group contiguous with
        // one invalid page, high group with gaps between every frame
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            r = shaped(OP_WRITE, 16'($urandom), 6'($urandom_range(32)), 16'($urandom));
            r.entry_index = 6'(i);
            if (i == 7)
                r.entry_value = 16'hE000;
            else if (i < 32)
                r.entry_value = 16'(i);
            else
                r.entry_value = {3'b000, 13'h1FFF - 13'(2 * (63 - i))};
            send_request(r);
        end

        run_directed();

        // random requests under three register settings and idle patterns
        for (int step = 0; step < 3; step++)
        begin
            settle();
            case (step)
                0:
                begin
                    send_idle_pct <= 22;
                    recv_idle_pct <= 51;
                    program_registers(25'd1, 6'd32, 8'hFF, 8'h00);
                    hold_armed <= 1'b1;
                end
                1:
                begin
                    send_idle_pct <= 51;
                    recv_idle_pct <= 22;
                    program_registers(25'h1000000, 6'($urandom_range(31)), 8'h00, 8'hFF);
                end
                default:
                begin
                    send_idle_pct <= 0;
                    recv_idle_pct <= 0;
                    program_registers(25'($urandom_range(16777216, 1)),
                                      6'($urandom_range(32)), 8'($urandom), 8'($urandom));
                end
            endcase
            for (int n = 0; n < ITEMS_PER_STEP; n++)
                send_request(random_request());
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.failures == 0)
            $display("page_table_address_translator test passed");
        else
            $display("page_table_address_translator test failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/pgxlat_pkg.sv
rtl/core/pgxlat_req_if.sv
rtl/core/pgxlat_rsp_if.sv
rtl/core/page_table_address_translator.sv
tb/page_table_address_translator_tb.sv
